// ----- hw/rtl/svg_pkg.sv -----
package svg_pkg;

  localparam int MAX_SEG_DEF       = 1024;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int SEG_W     = 11;
  localparam int DIV_STEPS = 31;
  localparam int REM_W     = 42;
  localparam int XY_W      = 34;
  localparam int Z_W       = 32;

  localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
  localparam logic [31:0] HALF_PI_Q28 = 32'd421657428;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [27:0] ATAN_Q28 [24] = '{
    28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422, 28'd8385879,
    28'd4193963, 28'd2097109, 28'd1048571, 28'd524287, 28'd262144, 28'd131072,
    28'd65536, 28'd32768, 28'd16384, 28'd8192, 28'd4096, 28'd2048,
    28'd1024, 28'd512, 28'd256, 28'd128, 28'd64, 28'd32
  };

  localparam logic [1:0] CFG_SEG_AROUND = 2'd0;
  localparam logic [1:0] CFG_SEG_UP     = 2'd1;
  localparam logic [1:0] CFG_RADIUS     = 2'd2;
  localparam logic [1:0] CFG_MAX_THETA  = 2'd3;

  typedef struct packed {
    logic [9:0]  lat_index;
    logic [10:0] lon_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               bad_index;
  } out_item_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [2:0]  quad;
    logic [31:0] res;
  } red_t;

  typedef struct packed {
    logic        bad;
    logic [15:0] u;
    logic [15:0] v;
    logic [1:0]  qp;
    logic [1:0]  qt;
  } side_t;

endpackage

// ----- hw/rtl/svg_div_cell.sv -----
module svg_div_cell
  import svg_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SEG_W-1:0] den,
  input  div_lane_t        lane_i,
  output div_lane_t        lane_o
);

  logic [REM_W-1:0] dsh;
  div_lane_t        lane_nxt;
  div_lane_t        lane_r;

  assign dsh = REM_W'(den) << BIT;

  // one quotient bit per cell
  always_comb begin
    lane_nxt = lane_i;
    if (lane_i.rem >= dsh) begin
      lane_nxt.rem      = lane_i.rem - dsh;
      lane_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane_r <= lane_nxt;
  end

  assign lane_o = lane_r;

endmodule

// ----- hw/rtl/svg_cordic_cell.sv -----
module svg_cordic_cell
  import svg_pkg::*;
#(
  parameter int K = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t c_i,
  output cordic_t c_o
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  atn;
  cordic_t                c_nxt;
  cordic_t                c_r;

  assign dx  = c_i.y >>> K;
  assign dy  = c_i.x >>> K;
  assign atn = signed'({4'b0, ATAN_Q28[K]});

  always_comb begin
    c_nxt = c_i;
    if (!c_i.z[Z_W-1]) begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - atn;
    end else begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + atn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  assign c_o = c_r;

endmodule

// ----- hw/rtl/sphere_vertex_generator_unit.sv -----
// UV sphere vertex generator. Each word names one grid point (ring, column) and gives back
// position, unit normal, tangent and texture coordinates. One word is taken every cycle
// unless the output word is held. The chain: an input register, 31 long-division cells (one
// quotient bit each) for the angles and texture coordinates, a quadrant stage, the CORDIC
// cell chain, two arithmetic stages and the output register. When the output word is held
// the whole chain stalls together. Configuration is to be written only with the chain empty.
module sphere_vertex_generator_unit
  import svg_pkg::*;
#(
  parameter int MAX_SEG       = MAX_SEG_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  localparam int ST_QUAD = DIV_STEPS + 1;
  localparam int ST_P1   = ST_QUAD + CORDIC_STAGES + 1;
  localparam int NST     = ST_P1 + 3;

  logic [SEG_W-1:0] seg_around_r;
  logic [SEG_W-1:0] seg_up_r;
  logic [14:0]      radius_r;
  logic [15:0]      max_theta_r;

  logic             en;
  logic [SEG_W-1:0] dm1;
  logic             bad_in;
  logic             vld_r  [NST];
  side_t            side_r [NST];
  side_t            side_q;

  div_lane_t        div_w  [4][DIV_STEPS+1];
  div_lane_t        num_nxt [4];
  cordic_t          cord_w [2][CORDIC_STAGES+1];
  red_t             red_p;
  red_t             red_t_;

  logic signed [15:0] cp_r, sp_r, ct_r, st_r;
  logic signed [15:0] n0_r, n1_r, n2_r, tx_r, tz_r;
  logic signed [XY_W-1:0] cx_p, sx_p, cx_t, sx_t;
  out_item_t          out_r;
  out_item_t          out_nxt;

  function automatic red_t reduce(input logic [30:0] a);
    red_t        r;
    logic [31:0] aw;
    logic [2:0]  n;
    aw = {1'b0, a};
    n  = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (aw >= 32'(k) * HALF_PI_Q28) n = n + 3'd1;
    end
    r.quad = n;
    r.res  = aw - 32'(n) * HALF_PI_Q28;
    return r;
  endfunction

  function automatic logic signed [15:0] rnd14(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] t;
    t = (signed'((XY_W+1)'(v)) + signed'((XY_W+1)'(32768))) >>> 16;
    if (t > 16384) return 16'sd16384;
    if (t < -16384) return -16'sd16384;
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] mulq(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    logic signed [31:0] p;
    p = (32'(a) * 32'(b) + 32'sd8192) >>> 14;
    if (p > 16384) return 16'sd16384;
    if (p < -16384) return -16'sd16384;
    return p[15:0];
  endfunction

  function automatic logic signed [15:0] posq(input logic signed [15:0] n,
                                              input logic [14:0] r);
    logic signed [31:0] p;
    p = (32'(n) * signed'({17'b0, r}) + 32'sd8192) >>> 14;
    if (p > 32767) return 16'sd32767;
    if (p < -32767) return -16'sd32767;
    return p[15:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_around_r <= SEG_W'(32);
      seg_up_r     <= SEG_W'(16);
      radius_r     <= 15'd256;
      max_theta_r  <= 16'd51472;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SEG_AROUND: seg_around_r <= cfg_wdata[SEG_W-1:0];
        CFG_SEG_UP:     seg_up_r     <= cfg_wdata[SEG_W-1:0];
        CFG_RADIUS:     radius_r     <= cfg_wdata[14:0];
        CFG_MAX_THETA:  max_theta_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !vld_r[NST-1] || out_ready;
  assign in_ready = en;
  assign dm1      = seg_up_r - SEG_W'(1);

  assign bad_in = (seg_around_r < SEG_W'(3)) || (32'(seg_around_r) > 32'(MAX_SEG)) ||
                  (seg_up_r < SEG_W'(3)) || (32'(seg_up_r) > 32'(MAX_SEG)) ||
                  ({1'b0, in_data.lat_index} >= seg_up_r) ||
                  (in_data.lon_index > seg_around_r);

  // numerators with the half-divisor for round half up
  always_comb begin
    num_nxt[0].rem = REM_W'(in_data.lon_index) * REM_W'(TWO_PI_Q28)
                   + REM_W'(seg_around_r >> 1);
    num_nxt[1].rem = ((REM_W'(in_data.lat_index) * REM_W'(max_theta_r)) << 14)
                   + REM_W'(dm1 >> 1);
    num_nxt[2].rem = (REM_W'(in_data.lon_index) << 15) + REM_W'(seg_around_r >> 1);
    num_nxt[3].rem = (REM_W'(in_data.lat_index) << 15) + REM_W'(dm1 >> 1);
    for (int l = 0; l < 4; l++) num_nxt[l].quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) div_w[l][0] <= num_nxt[l];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      svg_div_cell #(.BIT(DIV_STEPS - 1 - s)) u_div (
        .clk    (clk),
        .en     (en),
        .den    ((l % 2 == 0) ? seg_around_r : dm1),
        .lane_i (div_w[l][s]),
        .lane_o (div_w[l][s+1])
      );
    end
  end

  assign red_p  = reduce(div_w[0][DIV_STEPS].quo);
  assign red_t_ = reduce(div_w[1][DIV_STEPS].quo);

  always_ff @(posedge clk) begin
    if (en) begin
      cord_w[0][0] <= '{x: CORDIC_GAIN_Q30, y: '0, z: signed'(red_p.res)};
      cord_w[1][0] <= '{x: CORDIC_GAIN_Q30, y: '0, z: signed'(red_t_.res)};
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ang
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      svg_cordic_cell #(.K(k)) u_rot (
        .clk (clk),
        .en  (en),
        .c_i (cord_w[a][k]),
        .c_o (cord_w[a][k+1])
      );
    end
  end

  // valid and sideband shift lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // texture coordinates and quadrants join the sideband after the dividers
  always_comb begin
    side_q    = side_r[ST_QUAD-1];
    side_q.u  = div_w[2][DIV_STEPS].quo[15:0];
    side_q.v  = div_w[3][DIV_STEPS].quo[15:0];
    side_q.qp = red_p.quad[1:0];
    side_q.qt = red_t_.quad[1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{bad: bad_in, u: '0, v: '0, qp: '0, qt: '0};
      for (int i = 1; i < NST; i++) begin
        if (i == ST_QUAD) side_r[i] <= side_q;
        else side_r[i] <= side_r[i-1];
      end
    end
  end

  // quadrant rotation of the cordic results
  always_comb begin
    case (side_r[ST_P1-1].qp)
      2'd0:    begin cx_p =  cord_w[0][CORDIC_STAGES].x; sx_p =  cord_w[0][CORDIC_STAGES].y; end
      2'd1:    begin cx_p = -cord_w[0][CORDIC_STAGES].y; sx_p =  cord_w[0][CORDIC_STAGES].x; end
      2'd2:    begin cx_p = -cord_w[0][CORDIC_STAGES].x; sx_p = -cord_w[0][CORDIC_STAGES].y; end
      default: begin cx_p =  cord_w[0][CORDIC_STAGES].y; sx_p = -cord_w[0][CORDIC_STAGES].x; end
    endcase
    case (side_r[ST_P1-1].qt)
      2'd0:    begin cx_t =  cord_w[1][CORDIC_STAGES].x; sx_t =  cord_w[1][CORDIC_STAGES].y; end
      2'd1:    begin cx_t = -cord_w[1][CORDIC_STAGES].y; sx_t =  cord_w[1][CORDIC_STAGES].x; end
      2'd2:    begin cx_t = -cord_w[1][CORDIC_STAGES].x; sx_t = -cord_w[1][CORDIC_STAGES].y; end
      default: begin cx_t =  cord_w[1][CORDIC_STAGES].y; sx_t = -cord_w[1][CORDIC_STAGES].x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r <= rnd14(cx_p);
      sp_r <= rnd14(sx_p);
      ct_r <= rnd14(cx_t);
      st_r <= rnd14(sx_t);
      n0_r <= mulq(cp_r, st_r);
      n1_r <= -ct_r;
      n2_r <= -mulq(sp_r, st_r);
      tx_r <= -sp_r;
      tz_r <= -cp_r;
      out_r <= out_nxt;
    end
  end

  // rejected words come out as zeros with the flag set
  always_comb begin
    out_nxt = '0;
    if (side_r[ST_P1+1].bad) begin
      out_nxt.bad_index = 1'b1;
    end else begin
      out_nxt.pos_x = posq(n0_r, radius_r);
      out_nxt.pos_y = posq(n1_r, radius_r);
      out_nxt.pos_z = posq(n2_r, radius_r);
      out_nxt.nrm_x = n0_r;
      out_nxt.nrm_y = n1_r;
      out_nxt.nrm_z = n2_r;
      out_nxt.tan_x = tx_r;
      out_nxt.tan_z = tz_r;
      out_nxt.tex_u = side_r[ST_P1+1].u;
      out_nxt.tex_v = side_r[ST_P1+1].v;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

endmodule
